@@ sv/timed_event_scheduler_defines.svh @@
// Assertion macros shared by the timed event scheduler RTL.
`ifndef TIMED_EVENT_SCHEDULER_DEFINES_SVH
`define TIMED_EVENT_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define TES_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define TES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TES_ASSERT(lbl, clk, rst, prop, msg)

`define TES_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ sv/tes_pkg.sv @@
// Types and constants of the timed event scheduler.
package tes_pkg;

   // Default table depth and stored id width.
   localparam int DEF_MAX_EVENTS = 32;
   localparam int DEF_ID_BITS    = 16;

   // Most events reported by one advance request.
   localparam int OUT_CAP = 32;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_CLEAR   = 2'd1,
      OP_REWIND  = 2'd2,
      OP_ADVANCE = 2'd3
   } tes_op_type;

   typedef struct packed {
      tes_op_type  req_type;
      logic [31:0] time_value;
      logic [15:0] event_id;
   } req_beat_type;

   typedef struct packed {
      logic        fired;
      logic [15:0] fired_id;
      logic [31:0] fired_time;
      logic        last;
      logic        finished;
      logic        table_full;
      logic [31:0] cursor_time;
   } rsp_beat_type;

endpackage

@@ sv/timed_event_scheduler.sv @@
// Timed event scheduler: event table, playback cursor and scan sequencer.
`include "timed_event_scheduler_defines.svh"

// The scheduler keeps a table of MAX_EVENTS timed events (a 16.16 due time and an id)
// and one playback cursor, and takes one request beat at a time; req_ready is high only
// while no request is in work. Every request answers with one or more response beats,
// the final one flagged by last. All work is done by one magnitude comparator and one
// read port of the event memory, stepping through the slots one per cycle. An add
// scans the valid bits for the lowest free slot, a clear needs no scan, a rewind
// takes one scan, and an advance takes one counting scan plus one minimum-search
// scan per reported event, each response beat waiting for rsp_ready. The event
// memory has no reset and needs no clearing pass: per-slot valid and pending bits
// in flip-flops are cleared by reset and by a clear request, and a slot's time and
// id are used only while it is valid.
module timed_event_scheduler
   import tes_pkg::*;
#(
   parameter int MAX_EVENTS = DEF_MAX_EVENTS,
   parameter int ID_BITS    = DEF_ID_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_data
);

   localparam int AW = $clog2(MAX_EVENTS);
   localparam int CW = $clog2(MAX_EVENTS + 1);

   // One-hot sequencer states.
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_ADD  = 6'b000010,
      ST_REW  = 6'b000100,
      ST_CNT  = 6'b001000,
      ST_PICK = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Scan counter; it runs one step past the last slot to drain the memory read.
   logic [CW-1:0] cnt_ff, cnt_in;

   // Event memory with its registered read port.
   logic [31:0]        mem_time [MAX_EVENTS];
   logic [ID_BITS-1:0] mem_id   [MAX_EVENTS];
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      rd_idx_ff;
   logic [31:0]        rd_time_ff;
   logic [ID_BITS-1:0] rd_id_ff;
   logic               mem_we;

   // Payload of an add, held while the free slot is searched.
   logic [31:0]        add_time_ff, add_time_in;
   logic [ID_BITS-1:0] add_id_ff, add_id_in;

   // Per-slot flags.
   logic [MAX_EVENTS-1:0] valid_ff, valid_in;
   logic [MAX_EVENTS-1:0] pending_ff, pending_in;
   logic [MAX_EVENTS-1:0] elig_ff, elig_in;

   logic [31:0] cursor_ff, cursor_in;

   // Advance bookkeeping.
   logic [CW-1:0] pend_cnt_ff, pend_cnt_in;
   logic [CW-1:0] elig_cnt_ff, elig_cnt_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] k_ff, k_in;
   logic          fin_ff, fin_in;

   // Response bookkeeping.
   logic fired_ff, fired_in;
   logic full_ff, full_in;

   // Running minimum of the pick scan.
   logic               best_vld_ff, best_vld_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [31:0]        best_time_ff, best_time_in;
   logic [ID_BITS-1:0] best_id_ff, best_id_in;

   // Shared comparator.
   logic [31:0] cmp_a, cmp_b;
   logic        cmp_lt;

   logic          scan_end;
   logic          proc;
   logic          pend_hit;
   logic          elig_hit;
   logic [CW-1:0] pend_nxt;
   logic [CW-1:0] elig_nxt;
   logic [CW-1:0] n_cap;
   logic [32:0]   adv_sum;
   logic          out_last;
   logic          req_acc;
   logic          rsp_acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;

   assign scan_end = (cnt_ff == CW'(MAX_EVENTS));
   assign proc     = (cnt_ff != '0);
   assign rd_addr  = scan_end ? '0 : cnt_ff[AW-1:0];

   // The comparator's operands follow the scan being run.
   always_comb begin
      unique case (state_ff)
         ST_REW: begin
            cmp_a = rd_time_ff;
            cmp_b = cursor_ff;
         end
         ST_CNT: begin
            cmp_a = cursor_ff;
            cmp_b = rd_time_ff;
         end
         default: begin
            cmp_a = rd_time_ff;
            cmp_b = best_time_ff;
         end
      endcase
   end

   assign cmp_lt = (cmp_a < cmp_b);

   assign pend_hit = proc && pending_ff[rd_idx_ff];
   assign elig_hit = pend_hit && !cmp_lt;
   assign pend_nxt = pend_cnt_ff + CW'(pend_hit);
   assign elig_nxt = elig_cnt_ff + CW'(elig_hit);
   assign n_cap    = (int'(elig_nxt) > OUT_CAP) ? CW'(OUT_CAP) : elig_nxt;

   assign adv_sum  = {1'b0, cursor_ff} + {1'b0, req_data.time_value};
   assign out_last = fired_ff ? ((k_ff + CW'(1)) == n_ff) : 1'b1;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      pending_in   = pending_ff;
      elig_in      = elig_ff;
      cursor_in    = cursor_ff;
      pend_cnt_in  = pend_cnt_ff;
      elig_cnt_in  = elig_cnt_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      fin_in       = fin_ff;
      fired_in     = fired_ff;
      full_in      = full_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_time_in = best_time_ff;
      best_id_in   = best_id_ff;
      add_time_in  = add_time_ff;
      add_id_in    = add_id_ff;
      mem_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cnt_in      = '0;
               fired_in    = 1'b0;
               full_in     = 1'b0;
               add_time_in = req_data.time_value;
               add_id_in   = ID_BITS'(req_data.event_id);
               unique case (req_data.req_type)
                  OP_ADD: begin
                     state_in = ST_ADD;
                  end
                  OP_CLEAR: begin
                     valid_in   = '0;
                     pending_in = '0;
                     state_in   = ST_OUT;
                  end
                  OP_REWIND: begin
                     cursor_in = req_data.time_value;
                     state_in  = ST_REW;
                  end
                  OP_ADVANCE: begin
                     cursor_in   = adv_sum[32] ? '1 : adv_sum[31:0];
                     elig_in     = '0;
                     pend_cnt_in = '0;
                     elig_cnt_in = '0;
                     state_in    = ST_CNT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Walk the valid bits for the lowest free slot.
         ST_ADD: begin
            if (scan_end) begin
               full_in  = 1'b1;
               state_in = ST_OUT;
            end else if (!valid_ff[rd_addr]) begin
               mem_we            = 1'b1;
               valid_in[rd_addr] = 1'b1;
               state_in          = ST_OUT;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         // A stored event is pending again if it is not due before the cursor.
         ST_REW: begin
            if (proc) begin
               pending_in[rd_idx_ff] = valid_ff[rd_idx_ff] && !cmp_lt;
            end
            if (scan_end) begin
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         // Count pending events and mark those already due.
         ST_CNT: begin
            pend_cnt_in = pend_nxt;
            elig_cnt_in = elig_nxt;
            if (elig_hit) begin
               elig_in[rd_idx_ff] = 1'b1;
            end
            if (scan_end) begin
               n_in   = n_cap;
               fin_in = (pend_nxt == n_cap);
               k_in   = '0;
               cnt_in = '0;
               if (n_cap == '0) begin
                  state_in = ST_OUT;
               end else begin
                  best_vld_in = 1'b0;
                  state_in    = ST_PICK;
               end
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         // Find the earliest due event; a strict compare keeps ties on the lower slot.
         ST_PICK: begin
            if (proc && elig_ff[rd_idx_ff] && (!best_vld_ff || cmp_lt)) begin
               best_vld_in  = 1'b1;
               best_idx_in  = rd_idx_ff;
               best_time_in = rd_time_ff;
               best_id_in   = rd_id_ff;
            end
            if (scan_end) begin
               fired_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         ST_OUT: begin
            if (rsp_acc) begin
               if (fired_ff) begin
                  pending_in[best_idx_ff] = 1'b0;
                  elig_in[best_idx_ff]    = 1'b0;
                  k_in                    = k_ff + CW'(1);
               end
               if (out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in      = '0;
                  best_vld_in = 1'b0;
                  state_in    = ST_PICK;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         valid_ff    <= '0;
         pending_ff  <= '0;
         elig_ff     <= '0;
         cursor_ff   <= '0;
         pend_cnt_ff <= '0;
         elig_cnt_ff <= '0;
         n_ff        <= '0;
         k_ff        <= '0;
         fin_ff      <= 1'b0;
         fired_ff    <= 1'b0;
         full_ff     <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         valid_ff    <= valid_in;
         pending_ff  <= pending_in;
         elig_ff     <= elig_in;
         cursor_ff   <= cursor_in;
         pend_cnt_ff <= pend_cnt_in;
         elig_cnt_ff <= elig_cnt_in;
         n_ff        <= n_in;
         k_ff        <= k_in;
         fin_ff      <= fin_in;
         fired_ff    <= fired_in;
         full_ff     <= full_in;
         best_vld_ff <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      best_id_ff   <= best_id_in;
      add_time_ff  <= add_time_in;
      add_id_ff    <= add_id_in;
   end

   // Event memory: one write port used by add, one registered read port used by scans.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_time[rd_addr] <= add_time_ff;
         mem_id[rd_addr]   <= add_id_ff;
      end
      rd_time_ff <= mem_time[rd_addr];
      rd_id_ff   <= mem_id[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   // The response is held steady by the registers behind it until it is taken.
   always_comb begin
      rsp_data.fired       = fired_ff;
      rsp_data.fired_id    = fired_ff ? 16'(best_id_ff) : '0;
      rsp_data.fired_time  = fired_ff ? best_time_ff : '0;
      rsp_data.last        = out_last;
      rsp_data.finished    = fired_ff ? fin_ff : ~|pending_ff;
      rsp_data.table_full  = full_ff;
      rsp_data.cursor_time = cursor_ff;
   end

   // The block never offers a response while it takes a request.
   `TES_ASSERT(a_no_overlap, clock, reset, !(rsp_valid && req_ready), "request taken during response")
   // A reported event must still be in the pending set when its beat goes out.
   `TES_ASSERT(a_fired_pending, clock, reset, (rsp_valid && rsp_data.fired) |-> pending_ff[best_idx_ff], "fired event not pending")
   // An advance never reports more events than it counted.
   `TES_ASSERT(a_fired_count, clock, reset, (rsp_valid && rsp_data.fired) |-> (k_ff < n_ff), "too many events reported")
   // Once the final beat is taken the block is ready for the next request.
   `TES_ASSERT(a_last_idle, clock, reset, (rsp_valid && rsp_ready && rsp_data.last) |=> req_ready, "not ready after final beat")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the timed event scheduler: directed table, random sessions.
`timescale 1ns / 1ps

module tb_top;
   import tes_pkg::*;

   // The block is built with its default depth and id width, so the local copy of
   // the table uses the same sizes.
   localparam int SLOTS          = DEF_MAX_EVENTS;
   localparam int RANDOM_ITEMS   = 400;
   // The receiver stops taking beats for a long stretch once this many requests
   // have gone in, so that a finished request sits in the block and the sender
   // is left offering the next one against a low req_ready.
   localparam int HOLDOFF_AT     = 100;
   localparam int HOLDOFF_CYCLES = 400;
   // A full advance (33 slot scans) plus the longest receiver gap fits well
   // inside this; no beat for this long means one was lost.
   localparam int STALL_LIMIT    = 5000;
   localparam int DRAIN_CYCLES   = 200;

   // One row of stimulus. Rows with has_answer carry a result that is plain from
   // the request alone; all others are checked against the scheduler copy below.
   typedef struct {
      req_beat_type rq;
      bit           has_answer;
      rsp_beat_type answer;
   } stim_item_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_beat_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_beat_type rsp_data;

   stim_item_type stim_items[$];
   rsp_beat_type  due_beats[$];
   int            mismatches  = 0;
   int            beats_seen  = 0;
   int            reqs_taken  = 0;

   // Scheduler copy: event table, pending set and the playback cursor.
   logic [31:0] ev_time [SLOTS];
   logic [15:0] ev_id [SLOTS];
   bit          ev_used [SLOTS];
   bit          ev_armed [SLOTS];
   logic [31:0] play_pos;

   timed_event_scheduler DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // The run can never legitimately take this long; reaching it means a hang.
   initial begin : watchdog
      #20_000_000;
      $display("[timed_event_scheduler] ERROR");
      $finish;
   end

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // A result that reports no event: the only kind that add, clear and rewind give.
   function automatic rsp_beat_type quiet_beat(logic [31:0] cur, logic fin, logic full);
      rsp_beat_type b;
      b             = '0;
      b.last        = 1'b1;
      b.finished    = fin;
      b.table_full  = full;
      b.cursor_time = cur;
      return b;
   endfunction

   function automatic bit nothing_armed();
      bit empty;
      empty = 1'b1;
      for (int i = 0; i < SLOTS; i++)
         if (ev_armed[i])
            empty = 1'b0;
      return empty;
   endfunction

   // Applies one accepted request to the scheduler copy and queues the beats it
   // must produce. Rows with a typed-in answer queue that answer instead, but
   // still move the copy forward so later rows are predicted from the right state.
   task automatic predict_request(input stim_item_type it);
      rsp_beat_type fresh[$];
      rsp_beat_type b;
      int           free_slot;
      int           best;
      int           picked[$];
      logic [32:0]  sum;
      bit           fin;

      case (it.rq.req_type)
         OP_ADD: begin
            // Lowest free slot wins; scanning downward leaves it in free_slot.
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!ev_used[i])
                  free_slot = i;
            if (free_slot < 0) begin
               fresh.push_back(quiet_beat(play_pos, nothing_armed(), 1'b1));
            end else begin
               // A new event is not armed here; only a rewind arms events.
               ev_time[free_slot] = it.rq.time_value;
               ev_id[free_slot]   = it.rq.event_id;
               ev_used[free_slot] = 1'b1;
               fresh.push_back(quiet_beat(play_pos, nothing_armed(), 1'b0));
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               ev_used[i]  = 1'b0;
               ev_armed[i] = 1'b0;
            end
            fresh.push_back(quiet_beat(play_pos, 1'b1, 1'b0));
         end
         OP_REWIND: begin
            play_pos = it.rq.time_value;
            for (int i = 0; i < SLOTS; i++)
               ev_armed[i] = ev_used[i] && (ev_time[i] >= play_pos);
            fresh.push_back(quiet_beat(play_pos, nothing_armed(), 1'b0));
         end
         default: begin
            // Advance: saturating add, then pick due events earliest first; the
            // strict compare keeps the lower slot on equal times.
            sum = {1'b0, play_pos} + {1'b0, it.rq.time_value};
            play_pos = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            best = 0;
            while (best >= 0 && picked.size() < OUT_CAP) begin
               best = -1;
               for (int i = 0; i < SLOTS; i++)
                  if (ev_armed[i] && ev_time[i] <= play_pos &&
                      (best < 0 || ev_time[i] < ev_time[best]))
                     best = i;
               if (best >= 0) begin
                  ev_armed[best] = 1'b0;
                  picked.push_back(best);
               end
            end
            // Status fields show the state after the whole request on every beat.
            fin = nothing_armed();
            if (picked.size() == 0) begin
               fresh.push_back(quiet_beat(play_pos, fin, 1'b0));
            end else begin
               foreach (picked[k]) begin
                  b             = quiet_beat(play_pos, fin, 1'b0);
                  b.fired       = 1'b1;
                  b.fired_id    = ev_id[picked[k]];
                  b.fired_time  = ev_time[picked[k]];
                  b.last        = (k == picked.size() - 1);
                  fresh.push_back(b);
               end
            end
         end
      endcase

      if (it.has_answer) begin
         due_beats.push_back(it.answer);
      end else begin
         foreach (fresh[k])
            due_beats.push_back(fresh[k]);
      end
   endtask

   task automatic push_item(tes_op_type op, logic [31:0] tv, logic [15:0] id);
      stim_item_type it;
      it.rq.req_type   = op;
      it.rq.time_value = tv;
      it.rq.event_id   = id;
      it.has_answer    = 1'b0;
      it.answer        = '0;
      stim_items.push_back(it);
   endtask

   // One directed row, repeated reps times with the time and the id stepping.
   task automatic add_row(tes_op_type op, logic [31:0] tv, logic [15:0] id, int reps,
                          logic [31:0] tstep, bit has_answer, rsp_beat_type answer);
      stim_item_type it;
      for (int r = 0; r < reps; r++) begin
         it.rq.req_type   = op;
         it.rq.time_value = tv + tstep * r;
         it.rq.event_id   = id + 16'(r);
         it.has_answer    = has_answer;
         it.answer        = answer;
         stim_items.push_back(it);
      end
   endtask

   task automatic build_directed_part();
      // Straight out of reset: empty table, cursor at zero.
      add_row(OP_ADVANCE, 32'h0000_0000, 16'h0000, 1, 32'h0, 1'b1,
              quiet_beat(32'h0, 1'b1, 1'b0));
      add_row(OP_REWIND,  32'h0000_0000, 16'h0000, 1, 32'h0, 1'b1,
              quiet_beat(32'h0, 1'b1, 1'b0));
      // Extreme times and ids, plus two events that tie on time.
      add_row(OP_ADD, 32'h0000_0000, 16'h0000, 1, 32'h0, 1'b1,
              quiet_beat(32'h0, 1'b1, 1'b0));
      add_row(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1, 32'h0, 1'b1,
              quiet_beat(32'h0, 1'b1, 1'b0));
      add_row(OP_ADD, 32'h0001_8000, 16'h1234, 1, 32'h0, 1'b1,
              quiet_beat(32'h0, 1'b1, 1'b0));
      add_row(OP_ADD, 32'h0001_8000, 16'h4321, 1, 32'h0, 1'b1,
              quiet_beat(32'h0, 1'b1, 1'b0));
      add_row(OP_REWIND,  32'h0000_0000, 16'h0000, 1, 32'h0, 1'b0, '0);
      // Fires the zero-time event, then the tied pair in slot order.
      add_row(OP_ADVANCE, 32'h0002_0000, 16'h0000, 1, 32'h0, 1'b0, '0);
      // Added during playback with a time already passed: must not fire.
      add_row(OP_ADD,     32'h0001_0000, 16'hABCD, 1, 32'h0, 1'b0, '0);
      // The cursor sum overflows and sticks at the top; only the top event fires.
      add_row(OP_ADVANCE, 32'hFFFF_FFFF, 16'h0000, 1, 32'h0, 1'b0, '0);
      add_row(OP_ADVANCE, 32'h0000_0000, 16'h0000, 1, 32'h0, 1'b1,
              quiet_beat(32'hFFFF_FFFF, 1'b1, 1'b0));
      // Rewind arms the late-added event, and the zero-time event stays out.
      add_row(OP_REWIND,  32'h0001_0000, 16'h0000, 1, 32'h0, 1'b0, '0);
      add_row(OP_ADVANCE, 32'h0000_8000, 16'h0000, 1, 32'h0, 1'b0, '0);
      add_row(OP_CLEAR,   32'h0000_0000, 16'h0000, 1, 32'h0, 1'b1,
              quiet_beat(32'h0001_8000, 1'b1, 1'b0));
      add_row(OP_REWIND,  32'h0000_0000, 16'h0000, 1, 32'h0, 1'b1,
              quiet_beat(32'h0, 1'b1, 1'b0));
      // Fill every slot, then one add too many is refused.
      add_row(OP_ADD, 32'h0000_0000, 16'h0100, SLOTS, 32'h0001_0000, 1'b1,
              quiet_beat(32'h0, 1'b1, 1'b0));
      add_row(OP_ADD, 32'h1234_5678, 16'h5555, 1, 32'h0, 1'b1,
              quiet_beat(32'h0, 1'b1, 1'b1));
      // All slots due at once: the longest burst of beats one request can give.
      add_row(OP_REWIND,  32'h0000_0000, 16'h0000, 1, 32'h0, 1'b0, '0);
      add_row(OP_ADVANCE, 32'hFFFF_FFFF, 16'h0000, 1, 32'h0, 1'b0, '0);
      add_row(OP_CLEAR,   32'hFFFF_FFFF, 16'hFFFF, 1, 32'h0, 1'b1,
              quiet_beat(32'hFFFF_FFFF, 1'b1, 1'b0));
   endtask

   // Random part. Most of it is whole sessions (clear, a batch of adds around one
   // base time, a rewind and a run of advances) so that playback is exercised
   // deeply; the rest is loose requests with random content.
   task automatic build_random_part(int count);
      int          end_count;
      int          n;
      logic [31:0] base;
      logic [31:0] t;

      end_count = stim_items.size() + count;
      while (stim_items.size() < end_count) begin
         if ($urandom_range(0, 9) < 8) begin
            push_item(OP_CLEAR, $urandom, 16'($urandom));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 8);
            case ($urandom_range(0, 3))
               0:       base = 32'hFFFF_FFFF - $urandom_range(0, 32'h0005_0000);
               1:       base = $urandom_range(0, 32'h0002_0000);
               default: base = $urandom;
            endcase
            repeat (n) begin
               t = ($urandom_range(0, 4) == 0) ? base
                                               : base + $urandom_range(0, 32'h0004_0000);
               push_item(OP_ADD, t, 16'($urandom));
            end
            if ($urandom_range(0, 2) == 0)
               push_item(OP_REWIND, base + $urandom_range(0, 32'h0002_0000), 16'($urandom));
            else
               push_item(OP_REWIND, base - $urandom_range(0, 32'h0001_0000), 16'($urandom));
            repeat ($urandom_range(2, 6)) begin
               case ($urandom_range(0, 9))
                  0: push_item(OP_ADD, base + $urandom_range(0, 32'h0004_0000),
                               16'($urandom));
                  1: push_item(OP_REWIND, base, 16'($urandom));
                  2: push_item(OP_ADVANCE, $urandom, 16'($urandom));
                  default: push_item(OP_ADVANCE, $urandom_range(0, 32'h0001_8000),
                                     16'($urandom));
               endcase
            end
         end else begin
            repeat ($urandom_range(1, 6))
               push_item(tes_op_type'($urandom_range(0, 3)), $urandom, 16'($urandom));
         end
      end
   endtask

   // Idle length: mostly none or short, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Request side: reset, then every row in order. The scheduler copy is updated
   // at the edge where the beat is taken, which is always earlier than any
   // response beat that the request can cause.
   initial begin : req_side
      int gap;
      int last_seen;
      int idle_cycles;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      play_pos   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         ev_used[i]  = 1'b0;
         ev_armed[i] = 1'b0;
      end
      build_directed_part();
      build_random_part(RANDOM_ITEMS);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < stim_items.size(); k++) begin
         // Every fifth stretch of rows goes back to back with no idling.
         gap = ((k / 30) % 5 == 4) ? 0 : idle_len();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= stim_items[k].rq;
         @(posedge clock);
         while (!req_ready)
            @(posedge clock);
         predict_request(stim_items[k]);
         reqs_taken++;
      end
      req_valid <= 1'b0;

      // Wait for every queued beat, giving up if the block goes quiet for too long.
      last_seen   = beats_seen;
      idle_cycles = 0;
      while (due_beats.size() != 0 && idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (beats_seen != last_seen) begin
            last_seen   = beats_seen;
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      if (due_beats.size() != 0)
         flag_mismatch("beats never delivered", due_beats.size(), 0);
      // Any stray beat after the last expected one shows up here.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("[timed_event_scheduler] OK");
      else
         $display("[timed_event_scheduler] ERROR");
      $finish;
   end

   // Response side: alternating ready runs and idle gaps, plus one long hold-off.
   initial begin : rsp_side
      int  run;
      int  hold;
      bit  holdoff_done;

      run          = 0;
      hold         = 0;
      holdoff_done = 1'b0;
      rsp_ready   <= 1'b0;
      forever begin
         @(posedge clock);
         if (!holdoff_done && reqs_taken >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            hold         = HOLDOFF_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (run > 0) begin
            run--;
         end else if (rsp_ready) begin
            rsp_ready <= 1'b0;
            run = idle_len();
         end else begin
            rsp_ready <= 1'b1;
            // Long ready runs give stretches with no idling on this side.
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                              : $urandom_range(1, 20);
         end
      end
   end

   // Every response beat taken is compared field by field with the oldest one due.
   always @(posedge clock) begin : rsp_check
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (due_beats.size() == 0) begin
            flag_mismatch("beat with nothing due, fired_id", 32'(rsp_data.fired_id), 0);
         end else begin
            want = due_beats.pop_front();
            if (rsp_data.fired !== want.fired)
               flag_mismatch("fired", 32'(rsp_data.fired), 32'(want.fired));
            if (rsp_data.fired_id !== want.fired_id)
               flag_mismatch("fired_id", 32'(rsp_data.fired_id), 32'(want.fired_id));
            if (rsp_data.fired_time !== want.fired_time)
               flag_mismatch("fired_time", rsp_data.fired_time, want.fired_time);
            if (rsp_data.last !== want.last)
               flag_mismatch("last", 32'(rsp_data.last), 32'(want.last));
            if (rsp_data.finished !== want.finished)
               flag_mismatch("finished", 32'(rsp_data.finished), 32'(want.finished));
            if (rsp_data.table_full !== want.table_full)
               flag_mismatch("table_full", 32'(rsp_data.table_full),
                             32'(want.table_full));
            if (rsp_data.cursor_time !== want.cursor_time)
               flag_mismatch("cursor_time", rsp_data.cursor_time, want.cursor_time);
         end
      end
   end

endmodule
